/* src/lrukc_pkg.sv */
// Shared types and constants for the keyed response cache.
// Holds command codes, sequencer states and the table write control struct.
// No dependencies.
`default_nettype none

package lrukc_pkg;

    // Fixed field widths of the stream words.
    localparam int KEY_WORD_W   = 64;
    localparam int KEY_LAST_W   = 56;
    localparam int NUM_KEY_IN   = 5;
    localparam int STAMP_W      = 31;
    localparam int WLEN_W       = 16;
    localparam int RLIM_W       = 16;
    localparam int CMD_W        = 2;
    localparam int SLOT_OUT_W   = 8;
    localparam int LEN_OUT_W    = 10;
    localparam int IN_TDATA_W   = 376;
    localparam int OUT_TDATA_W  = 24;

    // Command codes carried in the input tuser field.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } state_t;

    // Write strobes into the slot table.
    typedef struct packed {
        logic row_en;    // key, length and stamp of one slot
        logic stamp_en;  // stamp only
    } tbl_wr_t;

endpackage

`default_nettype wire

/* src/lrukc_table.sv */
// Slot table memories: key rows, stored lengths and access stamps.
// One registered read port and one write port. Depends on lrukc_pkg.
`default_nettype none

module lrukc_table
    import lrukc_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int KEY_W   = 320,
    parameter int LEN_W   = 10
)
(
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic      [KEY_W-1:0]           rd_key_reg,
    output logic      [LEN_W-1:0]           rd_len_reg,
    output logic      [STAMP_W-1:0]         rd_stamp_reg,
    input  wire tbl_wr_t                    wr,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire logic [KEY_W-1:0]           wr_key,
    input  wire logic [LEN_W-1:0]           wr_len,
    input  wire logic [STAMP_W-1:0]         wr_stamp
);

    logic [KEY_W-1:0]   key_mem   [ENTRIES];
    logic [LEN_W-1:0]   len_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];

    // Key and length rows change only on an insert.
    always_ff @(posedge clk)
    begin
        if (wr.row_en)
        begin
            key_mem[wr_addr] <= wr_key;
            len_mem[wr_addr] <= wr_len;
        end
    end

    // Stamps change on an insert and on a lookup hit.
    always_ff @(posedge clk)
    begin
        if (wr.row_en || wr.stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    // Registered read of one whole slot.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/lru_keyed_response_cache_unit.sv */
// Top level of the fully associative keyed response cache with LRU replacement.
// Holds the sequencer, slot valid bits and scan trackers. Depends on lrukc_pkg
// and lrukc_table.
//
// Usage: one input word on the s_ channel carries a command in s_tuser and the
// key, time, write length and read limit in s_tdata. Each input word yields
// exactly one output word on the m_ channel: hit in m_tuser, slot and length
// in m_tdata. The block takes one word at a time; s_tready is high only while
// the sequencer is idle.
//
// Lookup and insert walk the table one slot per cycle through the table's
// single read port, checking key match, first empty slot and oldest stamp in
// the same pass, then write back one slot (a lookup only on a hit). Such a word
// reaches m_tvalid after the scan, drain, write and response states, and the next
// word is taken once the sequencer is back in idle. A clear, a lookup with a zero
// read limit or an unused command goes from idle straight to the response state.
//
// Reset empties the table at once (valid bits are flip-flops). A stalled
// receiver holds the result in the output register; the next input word is
// still accepted, and its result waits until the output register is free.
`default_nettype none

module lru_keyed_response_cache_unit
    import lrukc_pkg::*;
#(
    parameter int ENTRIES       = 256,
    parameter int KEY_BYTES     = 40,
    parameter int PAYLOAD_BYTES = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // key_word_0, key_word_1, key_word_2, key_word_3, key_word_4,
    // now_seconds, write_length, read_limit, one zero pad bit
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic [CMD_W-1:0]       s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // slot, length, six zero pad bits
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // hit
    output logic                        m_tuser
);

    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int KEY_WORDS = (KEY_BYTES + 7) / 8;
    localparam int KEY_W     = KEY_WORDS * KEY_WORD_W;
    localparam int LEN_W     = $clog2(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [WLEN_W:0]   LEN_MAX  = (WLEN_W + 1)'(PAYLOAD_BYTES - 1);

    // Input field positions inside s_tdata.
    localparam int NOW_LSB  = (NUM_KEY_IN - 1) * KEY_WORD_W + KEY_LAST_W;
    localparam int WLEN_LSB = NOW_LSB + STAMP_W;
    localparam int RLIM_LSB = WLEN_LSB + WLEN_W;

    // Input field unpacking.
    logic [NUM_KEY_IN*KEY_WORD_W-1:0] in_key_full;
    logic [KEY_W-1:0]                 in_key;
    logic [STAMP_W-1:0]               in_now;
    logic [WLEN_W-1:0]                in_wlen;
    logic [RLIM_W-1:0]                in_rlim;
    cmd_t                             in_cmd;
    logic                             in_accept;

    assign in_key_full = {8'd0, s_tdata[NOW_LSB-1:0]};
    assign in_key      = in_key_full[KEY_W-1:0];
    assign in_now      = s_tdata[NOW_LSB +: STAMP_W];
    assign in_wlen     = s_tdata[WLEN_LSB +: WLEN_W];
    assign in_rlim     = s_tdata[RLIM_LSB +: RLIM_W];
    assign in_cmd      = cmd_t'(s_tuser);
    assign in_accept   = s_tvalid && s_tready;

    // Sequencer and captured command.
    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [LEN_W-1:0]   wlen_clip_reg;
    logic [RLIM_W-1:0]  rlim_m1_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [ENTRIES-1:0] slot_valid_reg, slot_valid_next;

    // Scan trackers.
    logic               match_found_reg, match_found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [LEN_W-1:0]   match_len_reg, match_len_next;
    logic               empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic               oldest_found_reg, oldest_found_next;
    logic [IDX_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [STAMP_W-1:0] oldest_stamp_reg, oldest_stamp_next;

    // Result and output registers.
    logic             res_hit_reg;
    logic [IDX_W-1:0] res_slot_reg;
    logic [LEN_W-1:0] res_len_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [LEN_OUT_W-1:0]  out_len_reg;

    // Sequencer outputs.
    logic             rd_en;
    logic             out_load;
    logic             wr_phase;
    tbl_wr_t          tbl_wr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] ins_idx;
    logic [LEN_W-1:0] lookup_len;

    // Table read data.
    logic [KEY_W-1:0]   rd_key_reg;
    logic [LEN_W-1:0]   rd_len_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    lrukc_table #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .LEN_W   (LEN_W)
    ) u_table (
        .clk          (clk),
        .rd_en        (rd_en),
        .rd_addr      (scan_idx_reg),
        .rd_key_reg   (rd_key_reg),
        .rd_len_reg   (rd_len_reg),
        .rd_stamp_reg (rd_stamp_reg),
        .wr           (tbl_wr),
        .wr_addr      (wr_addr),
        .wr_key       (key_reg),
        .wr_len       (wlen_clip_reg),
        .wr_stamp     (now_reg)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_cmd)
                        CMD_LOOKUP: state_next = (in_rlim == '0) ? ST_RESP : ST_SCAN;
                        CMD_INSERT: state_next = ST_SCAN;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_RESP;
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        wr_phase = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  rd_en    = 1'b1;
            ST_DRAIN: ;
            ST_WRITE: wr_phase = 1'b1;
            ST_RESP:  out_load = !out_valid_reg || m_tready;
            default:  ;
        endcase
    end

    // Slot chosen for an insert: match, else first empty, else oldest.
    always_comb
    begin
        if (match_found_reg)
        begin
            ins_idx = match_idx_reg;
        end
        else if (empty_found_reg)
        begin
            ins_idx = empty_idx_reg;
        end
        else
        begin
            ins_idx = oldest_idx_reg;
        end
    end

    // Table write strobes during the write-back cycle.
    always_comb
    begin
        tbl_wr.row_en   = wr_phase && (cmd_reg == CMD_INSERT);
        tbl_wr.stamp_en = wr_phase && (cmd_reg == CMD_LOOKUP) && match_found_reg;
        wr_addr         = (cmd_reg == CMD_INSERT) ? ins_idx : match_idx_reg;
    end

    // Stored length clipped to the read limit minus one.
    always_comb
    begin
        if (RLIM_W'(match_len_reg) > rlim_m1_reg)
        begin
            lookup_len = LEN_W'(rlim_m1_reg);
        end
        else
        begin
            lookup_len = match_len_reg;
        end
    end

    // Tracker updates from the compare stage.
    always_comb
    begin
        logic slot_ok;
        slot_ok           = cmp_vld_reg && slot_valid_reg[cmp_idx_reg];
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        match_len_next    = match_len_reg;
        empty_found_next  = empty_found_reg;
        empty_idx_next    = empty_idx_reg;
        oldest_found_next = oldest_found_reg;
        oldest_idx_next   = oldest_idx_reg;
        oldest_stamp_next = oldest_stamp_reg;
        if (in_accept)
        begin
            match_found_next  = 1'b0;
            empty_found_next  = 1'b0;
            oldest_found_next = 1'b0;
        end
        else
        begin
            if (slot_ok && !match_found_reg && (rd_key_reg == key_reg))
            begin
                match_found_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
                match_len_next   = rd_len_reg;
            end
            if (cmp_vld_reg && !slot_valid_reg[cmp_idx_reg] && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = cmp_idx_reg;
            end
            if (slot_ok && (!oldest_found_reg || (rd_stamp_reg < oldest_stamp_reg)))
            begin
                oldest_found_next = 1'b1;
                oldest_idx_next   = cmp_idx_reg;
                oldest_stamp_next = rd_stamp_reg;
            end
        end
    end

    // Valid bits: clear on a clear command, set on an insert.
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (in_accept && (in_cmd == CMD_CLEAR))
        begin
            slot_valid_next = '0;
        end
        else if (tbl_wr.row_en)
        begin
            slot_valid_next[ins_idx] = 1'b1;
        end
    end

    // Output word handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_valid_reg   <= '0;
            out_valid_reg    <= 1'b0;
            cmp_vld_reg      <= 1'b0;
            match_found_reg  <= 1'b0;
            empty_found_reg  <= 1'b0;
            oldest_found_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_valid_reg   <= slot_valid_next;
            out_valid_reg    <= out_valid_next;
            cmp_vld_reg      <= rd_en;
            match_found_reg  <= match_found_next;
            empty_found_reg  <= empty_found_next;
            oldest_found_reg <= oldest_found_next;
        end
    end

    // Captured command fields and scan counter.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= in_cmd;
            key_reg      <= in_key;
            now_reg      <= in_now;
            rlim_m1_reg  <= in_rlim - RLIM_W'(1);
            scan_idx_reg <= '0;
            if ({1'b0, in_wlen} > LEN_MAX)
            begin
                wlen_clip_reg <= LEN_W'(LEN_MAX);
            end
            else
            begin
                wlen_clip_reg <= LEN_W'(in_wlen);
            end
        end
        else if (rd_en)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        cmp_idx_reg      <= scan_idx_reg;
        match_idx_reg    <= match_idx_next;
        match_len_reg    <= match_len_next;
        empty_idx_reg    <= empty_idx_next;
        oldest_idx_reg   <= oldest_idx_next;
        oldest_stamp_reg <= oldest_stamp_next;
    end

    // Result of the current command; a miss leaves all fields zero.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_hit_reg  <= 1'b0;
            res_slot_reg <= '0;
            res_len_reg  <= '0;
        end
        else if (wr_phase)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                res_hit_reg  <= 1'b1;
                res_slot_reg <= ins_idx;
                res_len_reg  <= wlen_clip_reg;
            end
            else if (match_found_reg)
            begin
                res_hit_reg  <= 1'b1;
                res_slot_reg <= match_idx_reg;
                res_len_reg  <= lookup_len;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= SLOT_OUT_W'(res_slot_reg);
            out_len_reg  <= LEN_OUT_W'(res_len_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {(OUT_TDATA_W - SLOT_OUT_W - LEN_OUT_W)'(0), out_len_reg, out_slot_reg};

    // A full table with no match must still yield a victim slot.
    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && cmd_reg == CMD_INSERT && !match_found_reg
         && !empty_found_reg) |-> oldest_found_reg)
        else $error("insert reached write-back without a victim slot");

    // An insert always reports a hit.
    a_insert_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && cmd_reg == CMD_INSERT) |=> (m_tvalid && m_tuser))
        else $error("insert result without hit");

    // A miss carries zero slot and length.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result with nonzero slot or length");

    // The table is written only after a full scan has drained.
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_wr.row_en || tbl_wr.stamp_en) |-> $past(state_reg == ST_DRAIN))
        else $error("table write without a completed scan");

endmodule

`default_nettype wire
